// ===== hdl/dual_wheel_pi_speed_controller_top_defines.svh =====
// Assertion macros shared by the speed controller RTL.
// Included by modules that carry concurrent assertions.
`ifndef DUAL_WHEEL_PI_SPEED_CONTROLLER_TOP_DEFINES_SVH
`define DUAL_WHEEL_PI_SPEED_CONTROLLER_TOP_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define DW_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define DW_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/dwpi_pkg.sv =====
// Shared types, constants and helpers for the two-wheel PI speed controller.
// No dependencies.
`timescale 1ns / 1ps
package dwpi_pkg;
   localparam int GAIN_DEN_DEF   = 8;
   localparam int STALL_DUTY_DEF = 200;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 15;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP_ENABLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_LIMIT  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_FLOOR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_CEILING = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INTERVAL_MS  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_STALL_LIMIT  = 3'd7;
   localparam logic REQ_TICK   = 1'b0;
   localparam logic REQ_RESYNC = 1'b1;

   typedef struct packed {
      logic [7:0]  prop_gain;
      logic [7:0]  integ_gain;
      logic [14:0] integ_limit;
      logic [9:0]  duty_floor;
      logic [9:0]  duty_ceiling;
   } gains_type;

   // Per-lane control from the sequencer.
   typedef struct packed {
      logic start;     // begin speed division
      logic pi_go;     // run PI update with computed speed
      logic clear;     // clear integral and drive
   } lane_ctl_type;

   typedef struct packed {
      logic busy;
      logic div_done;
   } lane_sts_type;
endpackage

// ===== hdl/dwpi_lane.sv =====
// One wheel lane: serial speed divider, PI update, integral and drive state.
// Depends on dwpi_pkg.
`timescale 1ns / 1ps
module dwpi_lane import dwpi_pkg::*; #(
   parameter int GAIN_DEN = GAIN_DEN_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  lane_ctl_type       ctl,
   input  gains_type          gains,
   input  logic signed [31:0] delta,
   input  logic [31:0]        elapsed,
   input  logic signed [15:0] target,
   output lane_sts_type       sts,
   output logic signed [31:0] speed,
   output logic [9:0]         drive
);
   // Magnitude of delta*1000 fits in 42 bits.
   localparam int NUM_W = 42;
   localparam int CNT_W = $clog2(NUM_W + 1);
   localparam int DEN_W = $clog2(GAIN_DEN + 1) + 1;

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [32:0]      rem_ff, rem_in;
   logic [31:0]      den_ff, den_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic signed [31:0] speed_ff, speed_in;
   logic signed [15:0] integ_ff, integ_in;
   logic [9:0]         drive_ff, drive_in;
   // Product pipeline for the PI increment.
   logic signed [49:0] perr_ff, perr_in;
   logic signed [25:0] pint_ff, pint_in;
   logic signed [16:0] integ_new_ff, integ_new_in;
   logic               pi_stage_ff, pi_stage_in;

   logic signed [42:0] prod;
   logic [NUM_W-1:0]   mag;
   logic [33:0]        trial;
   logic signed [NUM_W:0] sq;
   logic signed [33:0] err;
   logic signed [34:0] isum;
   logic signed [50:0] incr;
   logic signed [50:0] quot;
   logic signed [51:0] dsum;
   logic signed [15:0] lim;

   always_comb begin
      prod  = 43'(delta) * 43'sd1000;
      mag   = prod[42] ? NUM_W'(-prod) : NUM_W'(prod);
      trial = {rem_ff, quo_ff[NUM_W-1]} - {2'b0, den_ff};
      quo_in = quo_ff; rem_in = rem_ff; den_in = den_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0; speed_in = speed_ff;
      sq = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      if (ctl.start) begin
         quo_in = mag; rem_in = '0; den_in = elapsed; neg_in = prod[42];
         cnt_in = CNT_W'(NUM_W); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0; done_in = 1'b1;
            if (sq > 43'sh7FFFFFFF) speed_in = 32'sh7FFFFFFF;
            else if (sq < -43'sh80000000) speed_in = -32'sh80000000;
            else speed_in = 32'(sq);
         end else begin
            cnt_in = cnt_ff - 1'b1;
            if (!trial[33]) begin
               rem_in = trial[32:0];
               quo_in = {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_in = {rem_ff[31:0], quo_ff[NUM_W-1]};
               quo_in = {quo_ff[NUM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_comb begin
      lim  = $signed({1'b0, gains.integ_limit});
      err  = 34'(target) - 34'(speed_ff);
      isum = 35'(integ_ff) + 35'(err);
      if (isum > 35'(lim)) integ_new_in = 17'(lim);
      else if (isum < -35'(lim)) integ_new_in = -17'(lim);
      else integ_new_in = 17'(isum);
      perr_in = 50'(err) * $signed({1'b0, gains.prop_gain});
      pint_in = 26'(integ_new_in) * $signed({1'b0, gains.integ_gain});
      pi_stage_in = ctl.pi_go;
      incr = 51'(perr_ff) + 51'(pint_ff);
      quot = incr / 51'(DEN_W'(GAIN_DEN));
      dsum = 52'($signed({1'b0, drive_ff})) + 52'(quot);
      integ_in = integ_ff;
      drive_in = drive_ff;
      if (ctl.clear) begin
         integ_in = '0; drive_in = '0;
      end else if (pi_stage_ff) begin
         if (target <= 0) begin
            integ_in = '0; drive_in = '0;
         end else begin
            integ_in = 16'(integ_new_ff);
            if (dsum < 52'($signed({1'b0, gains.duty_floor}))) drive_in = gains.duty_floor;
            else if (dsum > 52'($signed({1'b0, gains.duty_ceiling})))
               drive_in = gains.duty_ceiling;
            else drive_in = dsum[9:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; den_ff <= den_in; neg_ff <= neg_in;
      speed_ff <= speed_in; perr_ff <= perr_in; pint_ff <= pint_in;
      integ_new_ff <= integ_new_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; pi_stage_ff <= 1'b0;
         integ_ff <= '0; drive_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; pi_stage_ff <= pi_stage_in;
         integ_ff <= integ_in; drive_ff <= drive_in;
      end
   end

   assign sts.busy     = busy_ff;
   assign sts.div_done = done_ff;
   assign speed = speed_ff;
   assign drive = drive_ff;
endmodule

// ===== hdl/dual_wheel_pi_speed_controller_top.sv =====
// Top level of the two-wheel PI speed controller: sequencer, two lanes, merge.
// Depends on dwpi_pkg, dwpi_lane and the shared assertion macro header.
`timescale 1ns / 1ps
`include "dual_wheel_pi_speed_controller_top_defines.svh"
// Usage:
// The request channel (req_valid/req_stall) carries one request: a control
// tick or a resync with time, two encoder counts and two target speeds.
// Every request yields exactly one response on rsp_valid/rsp_stall.
// A resync or an idle tick (loop off or interval not reached) goes through the
// check and simple states to its response. An updating tick runs the speed
// division in both lanes at once, one quotient bit per cycle over 42 bits, then,
// unless a stall is detected, PI arithmetic in ST_PI1 and ST_PI2. One request
// is in flight at a time; req_stall is high while the block works or while a
// response waits in the output register. When the receiver holds rsp_stall, the
// response stays unchanged. Synchronous reset clears all loop state and loads the
// register defaults. The user must write registers through csr_we, csr_index and
// csr_wdata only while idle; the block itself does not enforce this.
module dual_wheel_pi_speed_controller_top import dwpi_pkg::*; #(
   parameter int GAIN_DEN   = GAIN_DEN_DEF,
   parameter int STALL_DUTY = STALL_DUTY_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_req_type,
   input  logic [31:0]           req_now_ms,
   input  logic signed [31:0]    req_left_count,
   input  logic signed [31:0]    req_right_count,
   input  logic signed [15:0]    req_left_target,
   input  logic signed [15:0]    req_right_target,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_updated,
   output logic                  rsp_stalled,
   output logic [9:0]            rsp_left_duty,
   output logic [9:0]            rsp_right_duty,
   output logic signed [31:0]    rsp_left_speed,
   output logic signed [31:0]    rsp_right_speed,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam logic [2:0] ST_IDLE = 3'd0, ST_DIV = 3'd1, ST_CHK = 3'd2,
                          ST_PI1 = 3'd3, ST_PI2 = 3'd4, ST_OUT = 3'd5, ST_SIMPLE = 3'd6;
   localparam logic [9:0] STALL_DUTY_V = 10'(STALL_DUTY);

   // Configuration registers.
   logic        en_ff;
   gains_type   gains_ff;
   logic [7:0]  ivl_ff, slim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff <= 1'b0;
         gains_ff <= '{prop_gain: 8'd3, integ_gain: 8'd1, integ_limit: 15'd3000,
                       duty_floor: 10'd40, duty_ceiling: 10'd500};
         ivl_ff <= 8'd20; slim_ff <= 8'd10;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOOP_ENABLE:  en_ff <= csr_wdata[0];
            CSR_PROP_GAIN:    gains_ff.prop_gain <= csr_wdata[7:0];
            CSR_INTEG_GAIN:   gains_ff.integ_gain <= csr_wdata[7:0];
            CSR_INTEG_LIMIT:  gains_ff.integ_limit <= csr_wdata[14:0];
            CSR_DUTY_FLOOR:   gains_ff.duty_floor <= csr_wdata[9:0];
            CSR_DUTY_CEILING: gains_ff.duty_ceiling <= csr_wdata[9:0];
            CSR_INTERVAL_MS:  ivl_ff <= csr_wdata[7:0];
            CSR_STALL_LIMIT:  slim_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   logic [2:0]  st_ff, st_in;
   logic [31:0] last_time_ff, last_time_in;
   logic [31:0] last_left_ff, last_left_in, last_right_ff, last_right_in;
   logic [7:0]  lstall_ff, lstall_in, rstall_ff, rstall_in;
   // Latched request.
   logic        typ_ff;
   logic [31:0] now_ff, lc_ff, rc_ff;
   logic signed [15:0] lt_ff, rt_ff;
   logic [31:0] elapsed_ff;
   logic signed [31:0] ld_ff, rd_ff;
   // Output register.
   logic        ov_ff, ov_in, oupd_ff, oupd_in, ostl_ff, ostl_in;
   logic [9:0]  old_ff, old_in, ord_ff, ord_in;
   logic signed [31:0] ols_ff, ols_in, ors_ff, ors_in;

   lane_ctl_type ctl;
   lane_sts_type lsts, rsts;
   logic signed [31:0] lspeed, rspeed;
   logic [9:0] ldrive, rdrive;

   logic        acc;
   logic [31:0] elapsed;
   logic [7:0]  ivl_eff;
   logic        fire;

   dwpi_lane #(.GAIN_DEN(GAIN_DEN)) u_left (
      .clock, .reset, .ctl, .gains(gains_ff), .delta(ld_ff), .elapsed(elapsed_ff),
      .target(lt_ff), .sts(lsts), .speed(lspeed), .drive(ldrive));
   dwpi_lane #(.GAIN_DEN(GAIN_DEN)) u_right (
      .clock, .reset, .ctl, .gains(gains_ff), .delta(rd_ff), .elapsed(elapsed_ff),
      .target(rt_ff), .sts(rsts), .speed(rspeed), .drive(rdrive));

   function automatic logic [7:0] stall_next(input logic [7:0] c, input logic signed [15:0] t,
                                             input logic signed [31:0] d, input logic [9:0] dr,
                                             input logic [9:0] sd);
      if (t > 0 && d == 0 && dr > sd) return (c == 8'd255) ? c : c + 1'b1;
      return 8'd0;
   endfunction

   assign req_stall = (st_ff != ST_IDLE) || ov_ff;
   assign acc = req_valid && !req_stall;
   assign elapsed = now_ff - last_time_ff;
   assign ivl_eff = (ivl_ff == 8'd0) ? 8'd1 : ivl_ff;

   always_comb begin
      st_in = st_ff; ctl = '0;
      last_time_in = last_time_ff; last_left_in = last_left_ff; last_right_in = last_right_ff;
      lstall_in = lstall_ff; rstall_in = rstall_ff;
      ov_in = ov_ff && rsp_stall; oupd_in = oupd_ff; ostl_in = ostl_ff;
      old_in = old_ff; ord_in = ord_ff; ols_in = ols_ff; ors_in = ors_ff;
      fire = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (acc) st_in = ST_CHK;
         ST_CHK: begin
            if (typ_ff == REQ_RESYNC) begin
               last_time_in = now_ff; last_left_in = lc_ff; last_right_in = rc_ff;
               lstall_in = '0; rstall_in = '0; ctl.clear = 1'b1;
               st_in = ST_SIMPLE;
            end else if (!en_ff || elapsed < {24'd0, ivl_eff}) begin
               st_in = ST_SIMPLE;
            end else begin
               ctl.start = 1'b1;
               last_time_in = now_ff; last_left_in = lc_ff; last_right_in = rc_ff;
               st_in = ST_DIV;
            end
         end
         ST_SIMPLE: begin
            ov_in = 1'b1; oupd_in = 1'b0; ostl_in = 1'b0;
            old_in = ldrive; ord_in = rdrive; ols_in = '0; ors_in = '0;
            st_in = ST_IDLE;
         end
         ST_DIV: if (lsts.div_done) begin
            lstall_in = stall_next(lstall_ff, lt_ff, ld_ff, ldrive, STALL_DUTY_V);
            rstall_in = stall_next(rstall_ff, rt_ff, rd_ff, rdrive, STALL_DUTY_V);
            fire = (lstall_in >= slim_ff) || (rstall_in >= slim_ff);
            if (fire) begin
               lstall_in = '0; rstall_in = '0; ctl.clear = 1'b1;
               ov_in = 1'b1; oupd_in = 1'b1; ostl_in = 1'b1;
               old_in = '0; ord_in = '0; ols_in = lspeed; ors_in = rspeed;
               st_in = ST_IDLE;
            end else begin
               ctl.pi_go = 1'b1;
               st_in = ST_PI1;
            end
         end
         ST_PI1: st_in = ST_PI2;
         ST_PI2: st_in = ST_OUT;
         ST_OUT: begin
            ov_in = 1'b1; oupd_in = 1'b1; ostl_in = 1'b0;
            old_in = ldrive; ord_in = rdrive; ols_in = lspeed; ors_in = rspeed;
            st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      // The deltas and the elapsed time are taken at acceptance, so they are
      // settled before the lanes start dividing.
      if (acc) begin
         typ_ff <= req_req_type; now_ff <= req_now_ms;
         lc_ff <= req_left_count; rc_ff <= req_right_count;
         lt_ff <= req_left_target; rt_ff <= req_right_target;
         elapsed_ff <= req_now_ms - last_time_ff;
         ld_ff <= req_left_count - last_left_ff;
         rd_ff <= req_right_count - last_right_ff;
      end
      oupd_ff <= oupd_in; ostl_ff <= ostl_in; old_ff <= old_in; ord_ff <= ord_in;
      ols_ff <= ols_in; ors_ff <= ors_in;
      if (reset) begin
         st_ff <= ST_IDLE; ov_ff <= 1'b0;
         last_time_ff <= '0; last_left_ff <= '0; last_right_ff <= '0;
         lstall_ff <= '0; rstall_ff <= '0;
      end else begin
         st_ff <= st_in; ov_ff <= ov_in;
         last_time_ff <= last_time_in; last_left_ff <= last_left_in;
         last_right_ff <= last_right_in; lstall_ff <= lstall_in; rstall_ff <= rstall_in;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_updated = oupd_ff;
   assign rsp_stalled = ostl_ff;
   assign rsp_left_duty = old_ff;
   assign rsp_right_duty = ord_ff;
   assign rsp_left_speed = ols_ff;
   assign rsp_right_speed = ors_ff;

   `DW_ASSERT_IMP(a_lanes_lockstep, clock, reset, 1'b1, lsts.busy == rsts.busy, "lanes diverged")
   `DW_ASSERT_IMP(a_no_accept_busy, clock, reset, st_ff != ST_IDLE, !acc, "accept while busy")
   `DW_ASSERT_NXT(a_stall_zero_duty, clock, reset, ov_in && ostl_in && !ov_ff,
                  rsp_left_duty == '0 && rsp_right_duty == '0, "shutdown duty nonzero")
endmodule
